[sv/ppf_pkg.sv]
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types, commands, CORDIC table and helpers of the path follower.
// ----------------------------------------------------------------------------
package ppf_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RADIUS = 3'd0,
    REG_MAXVEL = 3'd1,
    REG_DKP    = 3'd2,
    REG_DKI    = 3'd3,
    REG_DKD    = 3'd4,
    REG_RKP    = 3'd5,
    REG_RKI    = 3'd6,
    REG_RKD    = 3'd7
  } reg_idx_t;

  localparam int unsigned CORDIC_ITERS = 16;
  localparam int unsigned ANG_BITS     = 28;
  localparam int unsigned VEC_BITS     = 34;
  localparam int unsigned TRIG_BITS    = 17;
  localparam int signed   FULL_TURN    = 46080;
  localparam int signed   HALF_TURN    = 23040;
  localparam int signed   QUARTER_TURN = 11520;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN_REQ,
    ST_SCAN,
    ST_LAST_REQ,
    ST_LAST,
    ST_CROSS_REQ,
    ST_CROSS,
    ST_SEG_REQ,
    ST_SEG_A,
    ST_SEG_B,
    ST_BIS_MUL,
    ST_BIS_SQ,
    ST_BIS_CMP,
    ST_WRAP,
    ST_CORDIC,
    ST_ROT_MUL,
    ST_ROT_SUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_PID_MUL,
    ST_PID_SUM,
    ST_OUT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [11:0] rd_addr;
  } mem_ctl_t;

  function automatic logic signed [ANG_BITS-1:0] atan_entry(input logic [3:0] i);
    logic signed [ANG_BITS-1:0] v;
    case (i)
      4'd0:  v = 28'sd2949120;
      4'd1:  v = 28'sd1740967;
      4'd2:  v = 28'sd919879;
      4'd3:  v = 28'sd466945;
      4'd4:  v = 28'sd234379;
      4'd5:  v = 28'sd117304;
      4'd6:  v = 28'sd58666;
      4'd7:  v = 28'sd29335;
      4'd8:  v = 28'sd14668;
      4'd9:  v = 28'sd7334;
      4'd10: v = 28'sd3667;
      4'd11: v = 28'sd1833;
      4'd12: v = 28'sd917;
      4'd13: v = 28'sd458;
      4'd14: v = 28'sd229;
      default: v = 28'sd115;
    endcase
    return v;
  endfunction

endpackage

[sv/ppf_waypoint_mem.sv]
// ----------------------------------------------------------------------------
// ppf_waypoint_mem
// Waypoint store: x and y in one word, one write and one registered read.
// ----------------------------------------------------------------------------
module ppf_waypoint_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned ABITS = 8
) (
  input  logic                     clk,
  input  ppf_pkg::mem_ctl_t        ctl,
  input  logic [ABITS-1:0]         wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr[ABITS-1:0]];
    end
  end

endmodule

[sv/ppf_divider.sv]
// ----------------------------------------------------------------------------
// ppf_divider
// Signed restoring divider, one quotient bit a cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module ppf_divider #(
  parameter int unsigned NBITS = 48,
  parameter int unsigned DBITS = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NBITS-1:0] num,
  input  logic [DBITS-1:0]        den,
  output logic                    busy,
  output logic signed [NBITS-1:0] quo
);

  localparam int unsigned CBITS = $clog2(NBITS + 1);

  logic [NBITS-1:0] q;
  logic [DBITS:0]   rem;
  logic [DBITS-1:0] d;
  logic             neg;
  logic [CBITS-1:0] cnt;
  logic [DBITS+1:0] trial;

  assign trial = {rem, q[NBITS-1]} - {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CBITS'(NBITS);
      neg  <= num[NBITS-1];
      q    <= num[NBITS-1] ? NBITS'(-num) : NBITS'(num);
      rem  <= '0;
      d    <= den;
    end else if (busy) begin
      if (!trial[DBITS+1]) begin
        rem <= trial[DBITS:0];
        q   <= {q[NBITS-2:0], 1'b1};
      end else begin
        rem <= {rem[DBITS-1:0], q[NBITS-1]};
        q   <= {q[NBITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CBITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);

endmodule

[sv/pure_pursuit_path_follower.sv]
// ----------------------------------------------------------------------------
// pure_pursuit_path_follower
// Pure pursuit tracker for a differential-drive robot, Q8.8 fixed point.
// ----------------------------------------------------------------------------
// One request at a time. A pursuit step walks the waypoint memory (one read a
// cycle) at most twice; its time grows with the number of stored points and
// is set by the memory read port and the serial divider. Results wait in an
// output register; the next request is taken once the output is free.
module pure_pursuit_path_follower #(
  parameter int unsigned MAX_WAYPOINTS = 256,
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned BISECT_STEPS  = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   cmd,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [16:0]           heading_deg,
  input  logic                         reverse_dir,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           left_velocity,
  output logic signed [15:0]           right_velocity,
  output logic                         arrived_flag,
  output logic                         status
);

  localparam int unsigned AB  = (MAX_WAYPOINTS > 2) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned NB  = $clog2(MAX_WAYPOINTS + 1);
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DB  = CB + 1;
  localparam int unsigned SQB = 2 * DB + 1;
  localparam int unsigned BB  = BISECT_STEPS;
  localparam int unsigned KB  = $clog2(BISECT_STEPS + 1);
  localparam int unsigned PB  = DB + BB + 2;
  localparam int unsigned LB  = DB + 20;
  localparam int unsigned QB  = LB + 9;
  localparam int unsigned VB  = ppf_pkg::VEC_BITS;
  localparam int unsigned ZB  = ppf_pkg::ANG_BITS;
  localparam int unsigned TB  = ppf_pkg::TRIG_BITS;

  // configuration
  logic [14:0]        radius, max_vel;
  logic signed [15:0] dkp, dki, dkd, rkp, rki, rkd;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius  <= 15'd2560;
      max_vel <= 15'd25600;
      dkp <= 16'sd256; dki <= '0; dkd <= '0;
      rkp <= 16'sd256; rki <= '0; rkd <= '0;
    end else if (cfg_we) begin
      case (ppf_pkg::reg_idx_t'(cfg_index))
        ppf_pkg::REG_RADIUS: radius  <= cfg_data[14:0];
        ppf_pkg::REG_MAXVEL: max_vel <= cfg_data[14:0];
        ppf_pkg::REG_DKP:    dkp <= cfg_data;
        ppf_pkg::REG_DKI:    dki <= cfg_data;
        ppf_pkg::REG_DKD:    dkd <= cfg_data;
        ppf_pkg::REG_RKP:    rkp <= cfg_data;
        ppf_pkg::REG_RKI:    rki <= cfg_data;
        ppf_pkg::REG_RKD:    rkd <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [14:0] r_eff;
  assign r_eff = (radius == '0) ? 15'd1 : radius;
  logic [29:0] r2;
  always_ff @(posedge clk) r2 <= r_eff * r_eff;

  // state and request registers
  ppf_pkg::state_t state, state_next;
  logic [NB-1:0]   count;
  logic            arrived;
  logic signed [15:0] last_de, last_re;
  logic signed [31:0] sum_de, sum_re;
  logic signed [CB-1:0] px, py;
  logic signed [16:0]   hd;
  logic                 rev;

  logic accept;
  assign in_stall = (state != ppf_pkg::ST_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;

  // memory
  ppf_pkg::mem_ctl_t   mctl;
  logic [AB-1:0]       rd_addr;
  logic [2*CB-1:0]     rd_data;
  logic signed [CB-1:0] wx, wy;
  assign wx = rd_data[2*CB-1:CB];
  assign wy = rd_data[CB-1:0];

  ppf_waypoint_mem #(.DEPTH(MAX_WAYPOINTS), .WIDTH(2 * CB), .ABITS(AB)) u_mem (
    .clk(clk), .ctl(mctl), .wr_addr(count[AB-1:0]),
    .wr_data({point_x, point_y}), .rd_data(rd_data)
  );

  // squared distance of the word just read
  logic signed [DB-1:0] ddx, ddy;
  logic [SQB-1:0]       d2;
  assign ddx = DB'(wx) - DB'(px);
  assign ddy = DB'(wy) - DB'(py);
  assign d2  = SQB'(ddx * ddx) + SQB'(ddy * ddy);

  // walk
  logic [NB-1:0]   idx;
  logic [NB-1:0]   ci;
  logic [SQB-1:0]  best;
  logic            prev_in;
  logic signed [CB-1:0] lx, ly, x0, y0;
  logic signed [DB-1:0] sdx, sdy;
  logic [BB:0]     lo, hi, mid;
  logic [KB-1:0]   k;
  logic signed [PB-1:0] prx, pry;
  logic signed [DB-1:0] ex, ey;

  // trig
  logic signed [ZB-1:0]  z;
  logic signed [VB-1:0]  cx, cy;
  logic [3:0]            it;
  logic                  tneg;
  logic signed [LB-1:0]  m1, m2, m3, m4;
  logic signed [LB-1:0]  locx, locy;

  // divider
  logic            dv_start, dv_busy, dv_sel, dv_start_q, dv_ready;
  logic signed [QB-1:0] dv_num, dv_quo;
  ppf_divider #(.NBITS(QB), .DBITS(15)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(r_eff),
    .busy(dv_busy), .quo(dv_quo)
  );
  logic signed [15:0] ed, er;
  logic signed [31:0] pd_p, pd_d, pr_p, pr_d;
  logic signed [47:0] pd_i, pr_i;
  logic signed [33:0] s_de_n, s_re_n;
  logic signed [31:0] sum_de_n, sum_re_n;
  logic signed [47:0] fwd, rot;

  function automatic logic signed [15:0] sat16(input logic signed [QB:0] v);
    if (v > (QB + 1)'(32767)) return 16'sh7fff;
    if (v < -(QB + 1)'(32768)) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] clampv(input logic signed [41:0] v,
                                               input logic [14:0] lim);
    if (v > $signed({27'd0, lim})) return $signed({1'b0, lim});
    if (v < -$signed({27'd0, lim})) return -$signed({1'b0, lim});
    return v[15:0];
  endfunction

  logic last_idx;
  assign last_idx = (idx == count - 1'b1);

  assign dv_ready = (state == ppf_pkg::ST_DIV) && !dv_busy && !dv_start_q;

  always_comb begin
    state_next = state;
    case (state)
      ppf_pkg::ST_IDLE: begin
        if (accept) begin
          if (ppf_pkg::cmd_t'(cmd) == ppf_pkg::CMD_STEP) begin
            state_next = (count == '0) ? ppf_pkg::ST_DONE : ppf_pkg::ST_SCAN_REQ;
          end else begin
            state_next = ppf_pkg::ST_DONE;
          end
        end
      end
      ppf_pkg::ST_SCAN_REQ: state_next = ppf_pkg::ST_SCAN;
      ppf_pkg::ST_SCAN: if (last_idx) state_next = ppf_pkg::ST_LAST_REQ;
      ppf_pkg::ST_LAST_REQ: begin
        if (arrived || ci == count - 1'b1) state_next = ppf_pkg::ST_DONE;
        else state_next = ppf_pkg::ST_LAST;
      end
      ppf_pkg::ST_LAST: state_next = (d2 < SQB'(r2)) ? ppf_pkg::ST_WRAP
                                                     : ppf_pkg::ST_CROSS_REQ;
      ppf_pkg::ST_CROSS_REQ: state_next = ppf_pkg::ST_CROSS;
      ppf_pkg::ST_CROSS: begin
        if (idx != '0 && d2 > SQB'(r2) && prev_in && ci < idx)
          state_next = ppf_pkg::ST_SEG_REQ;
        else if (last_idx) state_next = ppf_pkg::ST_WRAP;
      end
      ppf_pkg::ST_SEG_REQ: state_next = ppf_pkg::ST_SEG_A;
      ppf_pkg::ST_SEG_A: state_next = ppf_pkg::ST_SEG_B;
      ppf_pkg::ST_SEG_B: state_next = ppf_pkg::ST_BIS_MUL;
      ppf_pkg::ST_BIS_MUL: state_next = ppf_pkg::ST_BIS_SQ;
      ppf_pkg::ST_BIS_SQ: state_next = ppf_pkg::ST_BIS_CMP;
      ppf_pkg::ST_BIS_CMP: state_next = (k == KB'(BB - 1)) ? ppf_pkg::ST_WRAP
                                                          : ppf_pkg::ST_BIS_MUL;
      ppf_pkg::ST_WRAP: state_next = ppf_pkg::ST_CORDIC;
      ppf_pkg::ST_CORDIC: if (it == 4'd15) state_next = ppf_pkg::ST_ROT_MUL;
      ppf_pkg::ST_ROT_MUL: state_next = ppf_pkg::ST_ROT_SUM;
      ppf_pkg::ST_ROT_SUM: state_next = ppf_pkg::ST_DIV_INIT;
      ppf_pkg::ST_DIV_INIT: state_next = ppf_pkg::ST_DIV;
      ppf_pkg::ST_DIV: begin
        if (dv_ready && dv_sel) state_next = ppf_pkg::ST_PID_MUL;
      end
      ppf_pkg::ST_PID_MUL: state_next = ppf_pkg::ST_PID_SUM;
      ppf_pkg::ST_PID_SUM: state_next = ppf_pkg::ST_OUT;
      ppf_pkg::ST_OUT: state_next = ppf_pkg::ST_IDLE;
      ppf_pkg::ST_DONE: state_next = ppf_pkg::ST_IDLE;
      default: state_next = ppf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mctl.wr_en   = accept && (ppf_pkg::cmd_t'(cmd) == ppf_pkg::CMD_APPEND)
                   && (count < NB'(MAX_WAYPOINTS));
    mctl.rd_en   = 1'b1;
    mctl.rd_addr = 12'(rd_addr);
    rd_addr      = idx[AB-1:0];
    case (state)
      ppf_pkg::ST_LAST_REQ: rd_addr = AB'(count - 1'b1);
      ppf_pkg::ST_SEG_REQ:  rd_addr = AB'(idx - 2'd2);
      ppf_pkg::ST_SEG_A:    rd_addr = idx[AB-1:0];
      ppf_pkg::ST_SCAN_REQ, ppf_pkg::ST_CROSS_REQ: rd_addr = '0;
      ppf_pkg::ST_SCAN, ppf_pkg::ST_CROSS: rd_addr = AB'(idx + 1'b1);
      default: rd_addr = idx[AB-1:0];
    endcase
  end

  // CORDIC step values
  logic signed [VB-1:0] xs, ys;
  assign xs = cx >>> it;
  assign ys = cy >>> it;
  assign dv_start = (state == ppf_pkg::ST_DIV_INIT) || (dv_ready && !dv_sel);

  assign sum_de_n = (s_de_n > 34'sh7fffffff) ? 32'sh7fffffff :
                    (s_de_n < -34'sh80000000) ? 32'sh80000000 : s_de_n[31:0];
  assign sum_re_n = (s_re_n > 34'sh7fffffff) ? 32'sh7fffffff :
                    (s_re_n < -34'sh80000000) ? 32'sh80000000 : s_re_n[31:0];
  assign s_de_n = 34'(sum_de) + 34'(ed);
  assign s_re_n = 34'(sum_re) + 34'(er);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ppf_pkg::ST_IDLE;
      count     <= '0;
      arrived   <= 1'b0;
      last_de   <= '0;
      last_re   <= '0;
      sum_de    <= '0;
      sum_re    <= '0;
      out_valid <= 1'b0;
      dv_sel    <= 1'b0;
      dv_start_q <= 1'b0;
    end else begin
      state <= state_next;
      dv_start_q <= dv_start;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ppf_pkg::ST_IDLE: begin
          if (accept) begin
            px <= point_x; py <= point_y; hd <= heading_deg; rev <= reverse_dir;
            left_velocity <= '0; right_velocity <= '0; status <= 1'b0;
            idx <= '0; ci <= '0;
            case (ppf_pkg::cmd_t'(cmd))
              ppf_pkg::CMD_CLEAR: begin
                count <= '0; arrived <= 1'b0;
              end
              ppf_pkg::CMD_APPEND: begin
                if (count < NB'(MAX_WAYPOINTS)) count <= count + 1'b1;
                else status <= 1'b1;
              end
              ppf_pkg::CMD_STEP: begin
                if (count == '0) begin
                  arrived <= 1'b1; last_de <= '0; last_re <= '0;
                  sum_de <= '0; sum_re <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ppf_pkg::ST_SCAN: begin
          if (idx == '0 || d2 < best) begin
            best <= d2; ci <= idx;
          end
          idx <= idx + 1'b1;
        end
        ppf_pkg::ST_LAST_REQ: begin
          if (arrived || ci == count - 1'b1) begin
            arrived <= 1'b1; last_de <= '0; last_re <= '0;
            sum_de <= '0; sum_re <= '0;
          end
          idx <= '0;
        end
        ppf_pkg::ST_LAST: begin
          lx <= wx; ly <= wy;
        end
        ppf_pkg::ST_CROSS: begin
          if (idx == ci) begin
            lx <= wx; ly <= wy;
          end
          prev_in <= d2 < SQB'(r2);
          idx <= idx + 1'b1;
        end
        ppf_pkg::ST_SEG_REQ: idx <= idx - 1'b1;
        ppf_pkg::ST_SEG_A: begin
          x0 <= wx; y0 <= wy; idx <= idx + 1'b1;
          lo <= '0; hi <= (BB + 1)'(1) << BB; k <= '0;
        end
        ppf_pkg::ST_SEG_B: begin
          sdx <= DB'(wx) - DB'(x0); sdy <= DB'(wy) - DB'(y0);
        end
        ppf_pkg::ST_BIS_MUL: begin
          mid <= (lo + hi) >> 1;
          prx <= PB'(sdx) * PB'((lo + hi) >> 1) + (PB'(1) <<< (BB - 1));
          pry <= PB'(sdy) * PB'((lo + hi) >> 1) + (PB'(1) <<< (BB - 1));
        end
        ppf_pkg::ST_BIS_SQ: begin
          lx <= CB'(DB'(x0) + DB'(prx >>> BB));
          ly <= CB'(DB'(y0) + DB'(pry >>> BB));
          ex <= DB'(x0) + DB'(prx >>> BB) - DB'(px);
          ey <= DB'(y0) + DB'(pry >>> BB) - DB'(py);
        end
        ppf_pkg::ST_BIS_CMP: begin
          if (SQB'(ex * ex) + SQB'(ey * ey) < SQB'(r2)) lo <= mid;
          else hi <= mid;
          k <= k + 1'b1;
        end
        ppf_pkg::ST_WRAP: begin
          logic signed [17:0] m;
          m = 18'(hd);
          if (m < 0) m = m + 18'sd46080;
          if (m < 0) m = m + 18'sd46080;
          if (m >= 18'sd46080) m = m - 18'sd46080;
          if (m >= 18'sd23040) m = m - 18'sd46080;
          tneg <= 1'b0;
          if (m > 18'sd11520) begin
            m = m - 18'sd23040; tneg <= 1'b1;
          end else if (m < -18'sd11520) begin
            m = m + 18'sd23040; tneg <= 1'b1;
          end
          z  <= ZB'(m) <<< 9;
          cx <= VB'(652032874);
          cy <= '0;
          it <= '0;
        end
        ppf_pkg::ST_CORDIC: begin
          if (z >= 0) begin
            cx <= cx - ys; cy <= cy + xs; z <= z - ppf_pkg::atan_entry(it);
          end else begin
            cx <= cx + ys; cy <= cy - xs; z <= z + ppf_pkg::atan_entry(it);
          end
          it <= it + 1'b1;
        end
        ppf_pkg::ST_ROT_MUL: begin
          logic signed [TB-1:0] c, s;
          logic signed [DB-1:0] dxl, dyl;
          c = TB'((cx + VB'(32768)) >>> 16);
          s = TB'((cy + VB'(32768)) >>> 16);
          if (tneg) begin c = -c; s = -s; end
          dxl = DB'(lx) - DB'(px);
          dyl = DB'(ly) - DB'(py);
          m1 <= LB'(dyl) * LB'(c);
          m2 <= LB'(dxl) * LB'(s);
          m3 <= LB'(dyl) * LB'(s);
          m4 <= LB'(dxl) * LB'(c);
        end
        ppf_pkg::ST_ROT_SUM: begin
          locx <= (m1 - m2 + LB'(8192)) >>> 14;
          locy <= (m3 + m4 + LB'(8192)) >>> 14;
          dv_sel <= 1'b0;
        end
        ppf_pkg::ST_DIV: begin
          if (dv_ready) begin
            if (!dv_sel) begin
              ed <= rev ? sat16(-(QB + 1)'(dv_quo)) : sat16((QB + 1)'(dv_quo));
              dv_sel <= 1'b1;
            end else begin
              er <= sat16((QB + 1)'(dv_quo));
            end
          end
        end
        ppf_pkg::ST_PID_MUL: begin
          pd_p <= dkp * ed;
          pd_i <= dki * sum_de_n;
          pd_d <= 32'(dkd * 17'(17'(ed) - 17'(last_de)));
          pr_p <= rkp * er;
          pr_i <= rki * sum_re_n;
          pr_d <= 32'(rkd * 17'(17'(er) - 17'(last_re)));
          sum_de <= sum_de_n; sum_re <= sum_re_n;
          last_de <= ed; last_re <= er;
        end
        ppf_pkg::ST_PID_SUM: begin
          fwd <= 48'(pd_p) + pd_i + 48'(pd_d);
          rot <= 48'(pr_p) + pr_i + 48'(pr_d);
        end
        ppf_pkg::ST_OUT: begin
          logic signed [41:0] f, r, lf, rt;
          f  = 42'(fwd >>> 8);
          r  = 42'(rot >>> 8);
          lf = rev ? -(f + r) : f + r;
          rt = rev ? -(f - r) : f - r;
          left_velocity  <= clampv(lf, max_vel);
          right_velocity <= clampv(rt, max_vel);
          arrived   <= 1'b0;
          out_valid <= 1'b1;
        end
        ppf_pkg::ST_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign dv_num = (state == ppf_pkg::ST_DIV) ? (QB'(locx) <<< 8) : (QB'(locy) <<< 8);
  assign arrived_flag = arrived;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ppf_pkg::ST_IDLE) |-> in_stall) else $error("accepted while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= NB'(MAX_WAYPOINTS)) else $error("waypoint count overflow");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (accept) |=> !out_valid) else $error("result before request done");
`endif

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pure_pursuit_path_follower. A directed table of
// requests runs first, then a full store, then random paths of waypoints
// and pursuit steps near them under several register settings. A built-in
// predictor gives each result the table lacks; all are checked in order
// on every field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  logic               clk, rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid, in_stall;
  logic [1:0]         cmd;
  logic signed [15:0] point_x, point_y;
  logic signed [16:0] heading_deg;
  logic               reverse_dir;
  logic               out_valid, out_stall;
  logic signed [15:0] left_velocity, right_velocity;
  logic               arrived_flag, status;

  pure_pursuit_path_follower u_dut (.*);

  typedef struct {
    logic signed [15:0] left, right;
    logic               arr, stat;
  } drive_t;

  typedef struct {
    ppf_pkg::cmd_t      op;
    logic signed [15:0] x, y;
    logic signed [16:0] h;
    logic               rev, typed;
    drive_t             want;
  } req_row_t;

  drive_t drive_q[$];
  int     errors = 0;
  bit     calm = 0;

  // follower state mirror
  longint wx[256], wy[256];
  int     wcount;
  bit     arrived;
  longint last_de, last_re, sum_de, sum_re;
  longint regs[8];

  localparam longint ATAN_TBL[16] = '{2949120, 1740967, 919879, 466945, 234379,
    117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint dist_sq(int i, longint px, longint py);
    longint dx, dy;
    dx = wx[i] - px;
    dy = wy[i] - py;
    return dx * dx + dy * dy;
  endfunction

  task automatic heading_trig(longint h, output longint c, output longint s);
    longint m, x, y, z, t, xs, ys;
    bit flip;
    m = h % 46080;
    x = 652032874;
    y = 0;
    flip = 0;
    if (m < 0) m += 46080;
    if (m >= 23040) m -= 46080;
    if (m > 11520) begin
      m -= 23040; flip = 1;
    end else if (m < -11520) begin
      m += 23040; flip = 1;
    end
    z = m * 512;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        t = x - ys; y = y + xs; z -= ATAN_TBL[i];
      end else begin
        t = x + ys; y = y - xs; z += ATAN_TBL[i];
      end
      x = t;
    end
    c = (x + 32768) >>> 16;
    s = (y + 32768) >>> 16;
    if (flip) begin
      c = -c; s = -s;
    end
  endtask

  task automatic follow(ppf_pkg::cmd_t op, longint px, longint py, longint h, bit rev,
                        output drive_t d);
    longint lft, rgt, r, r2, lx, ly, c, s, dx, dy, locx, locy, ed, er, fwd, rot;
    longint best, dd, x0, y0, ddx, ddy, lo, hi, mid, ex, ey;
    int ci;
    bit found;
    lft = 0; rgt = 0; ci = 0; found = 0;
    d.stat = 0;
    case (op)
      ppf_pkg::CMD_CLEAR: begin
        wcount = 0; arrived = 0;
      end
      ppf_pkg::CMD_APPEND: begin
        if (wcount < 256) begin
          wx[wcount] = px; wy[wcount] = py; wcount++;
        end else d.stat = 1;
      end
      ppf_pkg::CMD_STEP: begin
        if (wcount > 0) begin
          best = dist_sq(0, px, py);
          for (int i = 1; i < wcount; i++) begin
            dd = dist_sq(i, px, py);
            if (dd < best) begin
              best = dd; ci = i;
            end
          end
        end
        if (arrived || wcount == 0 || ci == wcount - 1) begin
          last_de = 0; last_re = 0; sum_de = 0; sum_re = 0;
          arrived = 1;
        end else begin
          r = regs[ppf_pkg::REG_RADIUS] != 0 ? regs[ppf_pkg::REG_RADIUS] : 1;
          r2 = r * r;
          if (dist_sq(wcount - 1, px, py) < r2) begin
            lx = wx[wcount-1]; ly = wy[wcount-1]; found = 1;
          end else begin
            lx = wx[ci]; ly = wy[ci];
          end
          for (int i = 1; i < wcount && !found; i++) begin
            if (dist_sq(i, px, py) > r2 && dist_sq(i - 1, px, py) < r2 && ci < i) begin
              x0 = wx[i-1]; y0 = wy[i-1];
              ddx = wx[i] - x0; ddy = wy[i] - y0;
              lo = 0; hi = 1024;
              for (int k = 0; k < 10; k++) begin
                mid = (lo + hi) / 2;
                lx = x0 + ((ddx * mid + 512) >>> 10);
                ly = y0 + ((ddy * mid + 512) >>> 10);
                ex = lx - px; ey = ly - py;
                if (ex * ex + ey * ey < r2) lo = mid; else hi = mid;
              end
              found = 1;
            end
          end
          heading_trig(h, c, s);
          dx = lx - px; dy = ly - py;
          locx = (dy * c - dx * s + 8192) >>> 14;
          locy = (dy * s + dx * c + 8192) >>> 14;
          ed = (locy * 256) / r;
          if (rev) ed = -ed;
          ed = sat(ed, -32768, 32767);
          er = sat((locx * 256) / r, -32768, 32767);
          sum_de = sat(sum_de + ed, -64'sd2147483648, 64'sd2147483647);
          sum_re = sat(sum_re + er, -64'sd2147483648, 64'sd2147483647);
          fwd = (regs[ppf_pkg::REG_DKP] * ed + regs[ppf_pkg::REG_DKI] * sum_de
                 + regs[ppf_pkg::REG_DKD] * (ed - last_de)) >>> 8;
          rot = (regs[ppf_pkg::REG_RKP] * er + regs[ppf_pkg::REG_RKI] * sum_re
                 + regs[ppf_pkg::REG_RKD] * (er - last_re)) >>> 8;
          last_de = ed; last_re = er;
          lft = fwd + rot; rgt = fwd - rot;
          if (rev) begin
            lft = -lft; rgt = -rgt;
          end
          lft = sat(lft, -regs[ppf_pkg::REG_MAXVEL], regs[ppf_pkg::REG_MAXVEL]);
          rgt = sat(rgt, -regs[ppf_pkg::REG_MAXVEL], regs[ppf_pkg::REG_MAXVEL]);
          arrived = 0;
        end
      end
      default: ;
    endcase
    d.left = lft[15:0];
    d.right = rgt[15:0];
    d.arr = arrived;
  endtask

  task automatic send(req_row_t rq);
    drive_t d;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= rq.op;
    point_x <= rq.x;
    point_y <= rq.y;
    heading_deg <= rq.h;
    reverse_dir <= rq.rev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    follow(rq.op, rq.x, rq.y, rq.h, rq.rev, d);
    drive_q.insert(drive_q.size(), rq.typed ? rq.want : d);
  endtask

  task automatic send_op(ppf_pkg::cmd_t op, int x, int y, int h, bit rev);
    req_row_t rq;
    rq.op = op; rq.x = 16'(x); rq.y = 16'(y); rq.h = 17'(h); rq.rev = rev;
    rq.typed = 0;
    send(rq);
  endtask

  // waits out the pipeline, then writes all eight registers
  task automatic load_regs(longint v[8]);
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= v[i][15:0];
      regs[i] = (i < 2) ? (v[i] & 32'h7fff) : longint'($signed(v[i][15:0]));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic longint pick_gain();
    case ($urandom_range(5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return $signed(16'($urandom_range(65535))) / (1 << $urandom_range(8));
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall, in-order check
  always @(posedge clk) begin
    drive_t e;
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 31);
    if (!rst && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected result l=%0d r=%0d", $time, left_velocity, right_velocity);
        errors++;
      end else begin
        e = drive_q.pop_front();
        if (left_velocity !== e.left) begin
          $display("%0t: left exp %0d got %0d", $time, e.left, left_velocity); errors++;
        end
        if (right_velocity !== e.right) begin
          $display("%0t: right exp %0d got %0d", $time, e.right, right_velocity); errors++;
        end
        if (arrived_flag !== e.arr) begin
          $display("%0t: arrived exp %0b got %0b", $time, e.arr, arrived_flag); errors++;
        end
        if (status !== e.stat) begin
          $display("%0t: status exp %0b got %0b", $time, e.stat, status); errors++;
        end
      end
    end
  end

  initial begin
    req_row_t table_rows[$];
    longint v[8];
    int sent, n, bx, by, px, py, span;
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0; in_valid = 0;
    cmd = ppf_pkg::CMD_NOP; point_x = 0; point_y = 0; heading_deg = 0; reverse_dir = 0;
    wcount = 0; arrived = 0; last_de = 0; last_re = 0; sum_de = 0; sum_re = 0;
    regs = '{2560, 25600, 256, 0, 0, 256, 0, 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    table_rows = '{
      '{ppf_pkg::CMD_STEP,   0, 0, 0, 0, 1, '{0, 0, 1, 0}},
      '{ppf_pkg::CMD_NOP,    0, 0, 0, 0, 1, '{0, 0, 1, 0}},
      '{ppf_pkg::CMD_CLEAR,  0, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   100, 100, 0, 0, 1, '{0, 0, 1, 0}},
      '{ppf_pkg::CMD_CLEAR,  0, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_APPEND, 0, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_APPEND, 1280, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_APPEND, 5120, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_APPEND, 5120, 5120, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_APPEND, 12800, 5120, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   0, 0, 0, 0, 0, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   0, 0, 11520, 1, 0, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   640, 0, -46080, 0, 0, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   640, 0, 46080, 1, 0, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   3000, 3000, -23040, 0, 0, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   -32768, -32768, 30000, 0, 0, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   5120, 4000, 65535 - 65536, 0, 0, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   640, 640, 0, 1, 0, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   32767, 32767, 0, 0, 1, '{0, 0, 1, 0}},
      '{ppf_pkg::CMD_STEP,   0, 0, 0, 0, 1, '{0, 0, 1, 0}},
      '{ppf_pkg::CMD_NOP,    -1, -1, -1, 1, 1, '{0, 0, 1, 0}},
      '{ppf_pkg::CMD_CLEAR,  0, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_APPEND, -32768, 32767, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_APPEND, 32767, -32768, 0, 0, 1, '{0, 0, 0, 0}},
      '{ppf_pkg::CMD_STEP,   -32768, 32767, -46080, 1, 0, '{0, 0, 0, 0}}
    };
    foreach (table_rows[i]) send(table_rows[i]);
    sent = table_rows.size();

    // full store, then an append past the end
    send_op(ppf_pkg::CMD_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < 257; i++)
      send_op(ppf_pkg::CMD_APPEND, i * 128 - 16384,
              $signed(16'($urandom_range(65535))) >>> 6, 0, 0);
    for (int i = 0; i < 3; i++)
      send_op(ppf_pkg::CMD_STEP, $urandom_range(32767) - 16384, 0,
              $urandom_range(92160) - 46080, $urandom_range(1));
    sent += 261;

    for (int ph = 0; sent < 580; ph++) begin
      case (ph % 4)
        0: v = '{0, 0, 32767, 32767, 32767, -32768, -32768, -32768};
        1: v = '{32767, 32767, -32768, 0, 32767, 32767, 0, -32768};
        2: v = '{1, 512, 256, 16, 64, 256, 16, 64};
        default: begin
          v[0] = $urandom_range(7) == 0 ? $urandom_range(32767) : $urandom_range(4096, 256);
          v[1] = $urandom_range(32767);
          for (int i = 2; i < 8; i++) v[i] = pick_gain();
        end
      endcase
      load_regs(v);
      calm = (ph == 3);
      send_op(ppf_pkg::CMD_CLEAR, 0, 0, 0, 0);
      n = $urandom_range(12, 2);
      span = int'((regs[ppf_pkg::REG_RADIUS] < 256 ? 256 : regs[ppf_pkg::REG_RADIUS]) * 2);
      bx = $urandom_range(16383) - 8192;
      by = $urandom_range(16383) - 8192;
      for (int i = 0; i < n; i++) begin
        send_op(ppf_pkg::CMD_APPEND, bx, by, 0, 0);
        bx = int'(sat(bx + int'($urandom_range(span)) - span / 3, -32768, 32767));
        by = int'(sat(by + int'($urandom_range(span)) - span / 3, -32768, 32767));
      end
      sent += n + 1;
      for (int j = 0; j < 40; j++) begin
        if ($urandom_range(9) == 0) begin
          send_op(ppf_pkg::cmd_t'($urandom_range(3)), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(92160) - 46080, $urandom_range(1));
        end else begin
          px = int'(wx[$urandom_range(wcount - 1)] + int'($urandom_range(span)) - span / 2);
          py = int'(wy[$urandom_range(wcount - 1)] + int'($urandom_range(span)) - span / 2);
          send_op(ppf_pkg::CMD_STEP, int'(sat(px, -32768, 32767)),
                  int'(sat(py, -32768, 32767)),
                  $urandom_range(92160) - 46080, $urandom_range(1));
        end
        sent++;
      end
    end
    calm = 0;
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && drive_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
